FILE: src/mt_pkg.sv
package mt_pkg;

  localparam int WORD_W        = 32;
  localparam int STATE_DEPTH   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int ADDR_W        = $clog2(STATE_DEPTH);

  localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(STATE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] DEPTH_IDX = ADDR_W'(STATE_DEPTH);
  localparam logic [ADDR_W-1:0] MID_FWD   = ADDR_W'(MIDDLE_OFFSET);
  localparam logic [ADDR_W-1:0] MID_WRAP  = ADDR_W'(STATE_DEPTH - MIDDLE_OFFSET);

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] LCG_MULT     = 32'd69069;
  localparam logic [WORD_W-1:0] SEED_RESET   = 32'd4357;

  localparam logic [1:0] ACT_RESEED = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_NEXT   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_HI,
    ST_SEED_LO,
    ST_TW_PRE,
    ST_TW_RD,
    ST_TW_WR,
    ST_GEN_RD,
    ST_GEN_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic seed_start;
    logic seed_hi;
    logic seed_wr;
    logic tw_pre;
    logic tw_rd;
    logic tw_wr;
    logic load_wr;
    logic gen_out;
  } cmd_t;

  typedef struct packed {
    logic pos_full;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

FILE: src/mt_ram.sv
module mt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: src/mt_ctrl.sv
module mt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    action_i,
  output logic          in_ready_o,
  input  mt_pkg::sts_t  sts_i,
  output mt_pkg::cmd_t  cmd_o
);

  mt_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mt_pkg::ST_SEED_HI;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (action_i)
            mt_pkg::ACT_RESEED: begin
              cmd_o.seed_start = 1'b1;
              state_d          = mt_pkg::ST_SEED_HI;
            end
            mt_pkg::ACT_LOAD: begin
              cmd_o.load_wr = 1'b1;
            end
            mt_pkg::ACT_NEXT: begin
              state_d = sts_i.pos_full ? mt_pkg::ST_TW_PRE : mt_pkg::ST_GEN_OUT;
            end
            default: ;
          endcase
        end
      end
      mt_pkg::ST_SEED_HI: begin
        cmd_o.seed_hi = 1'b1;
        state_d       = mt_pkg::ST_SEED_LO;
      end
      mt_pkg::ST_SEED_LO: begin
        cmd_o.seed_wr = 1'b1;
        state_d       = sts_i.idx_last ? mt_pkg::ST_IDLE : mt_pkg::ST_SEED_HI;
      end
      mt_pkg::ST_TW_PRE: begin
        cmd_o.tw_pre = 1'b1;
        state_d      = mt_pkg::ST_TW_RD;
      end
      mt_pkg::ST_TW_RD: begin
        cmd_o.tw_rd = 1'b1;
        state_d     = mt_pkg::ST_TW_WR;
      end
      mt_pkg::ST_TW_WR: begin
        cmd_o.tw_wr = 1'b1;
        state_d     = sts_i.idx_last ? mt_pkg::ST_GEN_RD : mt_pkg::ST_TW_RD;
      end
      mt_pkg::ST_GEN_RD: begin
        state_d = mt_pkg::ST_GEN_OUT;
      end
      mt_pkg::ST_GEN_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.gen_out = 1'b1;
          state_d       = mt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/mt_datapath.sv
module mt_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mt_pkg::cmd_t               cmd_i,
  output mt_pkg::sts_t               sts_o,
  input  logic                       seed_value_we_i,
  input  logic [mt_pkg::WORD_W-1:0]  seed_value_i,
  input  logic [mt_pkg::ADDR_W-1:0]  word_index_i,
  input  logic [mt_pkg::WORD_W-1:0]  word_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mt_pkg::WORD_W-1:0]  random_value_o
);

  function automatic logic [mt_pkg::WORD_W-1:0] temper(input logic [mt_pkg::WORD_W-1:0] x);
    logic [mt_pkg::WORD_W-1:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & mt_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mt_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  logic [mt_pkg::WORD_W-1:0] seed_q;
  logic [mt_pkg::WORD_W-1:0] s_q, s_d;
  logic [15:0]               hi_q;
  logic [mt_pkg::ADDR_W-1:0] idx_q;
  logic [mt_pkg::ADDR_W-1:0] pos_q;
  logic [mt_pkg::WORD_W-1:0] carry_q;
  logic [mt_pkg::WORD_W-1:0] out_q;
  logic                      out_valid_q;

  logic                      idx_last;
  logic                      pos_full;
  logic [mt_pkg::ADDR_W-1:0] nxt_addr;
  logic [mt_pkg::ADDR_W-1:0] mid_addr;
  logic [mt_pkg::ADDR_W-1:0] raddr_a;
  logic [mt_pkg::ADDR_W-1:0] waddr;
  logic [mt_pkg::WORD_W-1:0] wdata;
  logic                      we;
  logic [mt_pkg::WORD_W-1:0] rdata_a;
  logic [mt_pkg::WORD_W-1:0] rdata_b;
  logic [mt_pkg::WORD_W-1:0] y_mix;
  logic [mt_pkg::WORD_W-1:0] tw_word;
  logic                      twisting;
  logic                      load_ok;

  assign idx_last = (idx_q == mt_pkg::LAST_IDX);
  assign pos_full = (pos_q >= mt_pkg::DEPTH_IDX);
  assign nxt_addr = idx_last ? '0 : idx_q + 1'b1;
  assign mid_addr = (idx_q < mt_pkg::MID_WRAP) ? idx_q + mt_pkg::MID_FWD
                                               : idx_q - mt_pkg::MID_WRAP;
  assign twisting = cmd_i.tw_rd | cmd_i.tw_wr;
  assign load_ok  = (word_index_i < mt_pkg::DEPTH_IDX);

  always_comb begin
    if (cmd_i.tw_pre) begin
      raddr_a = '0;
    end else if (twisting) begin
      raddr_a = nxt_addr;
    end else if (pos_full) begin
      raddr_a = '0;
    end else begin
      raddr_a = pos_q;
    end
  end

  // x = upper bit of word i, lower bits of word i+1
  assign y_mix   = {carry_q[mt_pkg::WORD_W-1], rdata_a[mt_pkg::WORD_W-2:0]};
  assign tw_word = rdata_b ^ (y_mix >> 1) ^ (y_mix[0] ? mt_pkg::TWIST_MATRIX : '0);

  assign s_d = mt_pkg::WORD_W'(s_q * mt_pkg::LCG_MULT + 32'd1);

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = tw_word;
    if (cmd_i.seed_wr) begin
      we    = 1'b1;
      wdata = {hi_q, s_q[mt_pkg::WORD_W-1:16]};
    end else if (cmd_i.tw_wr) begin
      we = 1'b1;
    end else if (cmd_i.load_wr) begin
      we    = load_ok;
      waddr = word_index_i;
      wdata = word_value_i;
    end
  end

  mt_ram #(
    .WIDTH (mt_pkg::WORD_W),
    .DEPTH (mt_pkg::STATE_DEPTH)
  ) u_state_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (mid_addr),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= mt_pkg::SEED_RESET;
      s_q         <= mt_pkg::SEED_RESET;
      idx_q       <= '0;
      pos_q       <= mt_pkg::DEPTH_IDX;
      out_valid_q <= 1'b0;
    end else begin
      if (seed_value_we_i) begin
        seed_q <= seed_value_i;
      end
      if (cmd_i.seed_start) begin
        s_q   <= seed_q;
        idx_q <= '0;
      end else if (cmd_i.seed_hi || cmd_i.seed_wr) begin
        s_q <= s_d;
      end
      if (cmd_i.tw_pre) begin
        idx_q <= '0;
      end else if (cmd_i.seed_wr || cmd_i.tw_wr) begin
        idx_q <= idx_last ? '0 : idx_q + 1'b1;
      end
      if (cmd_i.load_wr || (cmd_i.seed_wr && idx_last)) begin
        pos_q <= mt_pkg::DEPTH_IDX;
      end else if (cmd_i.tw_wr && idx_last) begin
        pos_q <= '0;
      end else if (cmd_i.gen_out) begin
        pos_q <= pos_q + 1'b1;
      end
      if (cmd_i.gen_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_hi) begin
      hi_q <= s_q[mt_pkg::WORD_W-1:16];
    end
    if (cmd_i.tw_rd) begin
      carry_q <= rdata_a;
    end
    if (cmd_i.gen_out) begin
      out_q <= temper(rdata_a);
    end
  end

  assign sts_o.pos_full = pos_full;
  assign sts_o.idx_last = idx_last;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_q;

endmodule

FILE: src/mersenne_twister_generator.sv
// MT19937 generator, 32-bit words, 624-word state in one RAM (one write, two registered reads).
// A next-number transaction has an accepting cycle and a generate cycle, after which the
// result sits in the output register. The request that finds the position at 624 first runs
// the twist sweep: a set-up state, a read and a write state per word through the single write
// port and a read state, before its generate cycle. A reseed steps the 69069 congruential
// multiplier twice per word; the same fill runs after reset, so in_ready_o rises only once
// the fill has finished. A load is written in the cycle that accepts it. A finished
// result waits in the output register while the next transaction is accepted; a new result
// is held back only while that register is still full.
module mersenne_twister_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [9:0]  word_index_i,
  input  logic [31:0] word_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] random_value_o,
  input  logic        seed_value_we_i,
  input  logic [31:0] seed_value_i
);

  mt_pkg::cmd_t cmd;
  mt_pkg::sts_t sts;

  mt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mt_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .seed_value_we_i (seed_value_we_i),
    .seed_value_i    (seed_value_i),
    .word_index_i    (word_index_i),
    .word_value_i    (word_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .random_value_o  (random_value_o)
  );

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.seed_wr, cmd.tw_wr, cmd.load_wr}))
    else $error("state memory written from two sources");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.gen_out |=> out_valid_o)
    else $error("result lost after generation");

  a_busy_after_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == mt_pkg::ACT_NEXT) |=> !in_ready_o)
    else $error("accepted a transaction during generation");

endmodule
